[src/lsk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack package
// Opcodes, status codes, sequencer states and default sizing for the stack.
// ----------------------------------------------------------------------------
package lsk_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN,
    S_RESULT
  } lsk_state_t;

endpackage
`default_nettype wire

[src/lsk_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack command channel
// Valid/ready channel that carries an opcode and a data value.
// ----------------------------------------------------------------------------
interface lsk_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] data_value;

  modport source (output valid, output opcode, output data_value, input ready);
  modport sink   (input valid, input opcode, input data_value, output ready);
endinterface
`default_nettype wire

[src/lsk_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack result channel
// Valid/ready channel that carries the popped value, status and entry count.
// ----------------------------------------------------------------------------
interface lsk_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  modport source (output valid, output popped_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input entry_count, output ready);
endinterface
`default_nettype wire

[src/lsk_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[src/lifo_stack_with_key_removal.sv]
`timescale 1ns / 1ps
`default_nettype none
// Push, no-op and flagged cases: idle, then S_RESULT, which registers the result.
// Pop: idle, then S_POP_WAIT for the registered RAM read, then S_RESULT, which registers it.
// Remove: idle, then S_SCAN over every entry, then S_RESULT, which registers the result.
// Scan reads one entry a cycle, rewriting non-matches; a stalled result delays the next.
// A command is taken only while the sequencer is idle; a pending result does not block it.
// Synchronous reset empties the stack at once; entry contents are not cleared.
// ----------------------------------------------------------------------------
// LIFO stack with key removal
// Bounded stack of signed values with push, pop and remove-all-by-key.
// ----------------------------------------------------------------------------
module lifo_stack_with_key_removal
  import lsk_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  lsk_cmd_if.sink   cmd,
  lsk_rsp_if.source result
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  lsk_state_t         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      idx, idx_next;
  logic [CW-1:0]      wr, wr_next;
  logic signed [31:0] key, key_next;
  logic signed [31:0] res_popped, res_popped_next;
  logic [1:0]         res_status, res_status_next;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [31:0]        ram_wr_data;
  logic [AW-1:0]      ram_rd_addr;
  logic [31:0]        ram_rd_data;

  logic               take;
  logic               last;
  logic               load_out;
  logic [CW+4:0]      count_ext;

  lsk_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cmd.ready = (state == S_IDLE);
  assign take      = cmd.valid && cmd.ready;
  assign last      = (CW'(idx) == count - CW'(1));
  assign load_out  = (state == S_RESULT) && (!result.valid || result.ready);
  assign count_ext = {5'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    wr_next         = wr;
    key_next        = key;
    res_popped_next = res_popped;
    res_status_next = res_status;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = wr[AW-1:0];
    ram_wr_data     = ram_rd_data;
    ram_rd_addr     = idx + AW'(1);
    unique case (state)
      S_IDLE: begin
        if (take) begin
          key_next        = cmd.data_value;
          res_popped_next = '0;
          res_status_next = ST_OK;
          idx_next        = '0;
          wr_next         = '0;
          state_next      = S_RESULT;
          unique case (cmd.opcode)
            OP_PUSH: begin
              if (count == CW'(STACK_DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = count[AW-1:0];
                ram_wr_data = cmd.data_value;
                count_next  = count + CW'(1);
              end
            end
            OP_POP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                ram_rd_addr = AW'(count - CW'(1));
                count_next  = count - CW'(1);
                state_next  = S_POP_WAIT;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_status_next = ST_NOTFOUND;
              end else begin
                ram_rd_addr = '0;
                state_next  = S_SCAN;
              end
            end
            default: begin
              res_status_next = ST_OK;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        res_popped_next = $signed(ram_rd_data);
        state_next      = S_RESULT;
      end
      S_SCAN: begin
        if ($signed(ram_rd_data) != key) begin
          ram_wr_en = 1'b1;
          wr_next   = wr + CW'(1);
        end
        idx_next = idx + AW'(1);
        if (last) begin
          count_next      = wr_next;
          res_status_next = (wr_next == count) ? ST_NOTFOUND : ST_OK;
          state_next      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    wr         <= wr_next;
    key        <= key_next;
    res_popped <= res_popped_next;
    res_status <= res_status_next;
    if (load_out) begin
      result.popped_value <= res_popped;
      result.status       <= res_status;
      result.entry_count  <= count_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("entry count exceeds the stack depth");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (wr <= CW'(idx)))
    else $error("compaction write pointer passed the read pointer");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (take && cmd.opcode == OP_POP && count != '0) |=> (count == $past(count) - CW'(1)))
    else $error("pop did not lower the entry count");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (take && cmd.opcode == OP_PUSH && count != CW'(STACK_DEPTH))
      |=> (count == $past(count) + CW'(1)))
    else $error("push did not raise the entry count");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == ST_EMPTY) |-> (result.entry_count == 5'd0))
    else $error("empty status reported with a nonzero count");

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with key removal testbench
// Sends push, pop, no-op and remove-by-key commands through the command channel and
// compares every result against a queue-based model of the stack.
// A directed opening covers the empty, full and key-absent cases. Random
// traffic follows under several idle and stall patterns and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import lsk_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  typedef struct {
    logic [1:0]         opcode;
    logic signed [31:0] data_value;
  } stack_cmd_t;

  typedef struct {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsk_cmd_if cmd_ch();
  lsk_rsp_if rsp_ch();

  lifo_stack_with_key_removal #(.STACK_DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .result(rsp_ch)
  );

  stack_cmd_t         cmd_pending[$];
  stack_result_t      expected_results[$];
  logic signed [31:0] stack_shadow[$];
  logic signed [31:0] recent_values[$];
  int                 error_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  logic               hold_arm = 1'b0;
  int                 hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_PUSH;
    cmd_ch.data_value = '0;
    rsp_ch.ready = 1'b0;
  end

  task automatic predict_stack_op(input logic [1:0] op, input logic signed [31:0] value);
    stack_result_t      res;
    logic signed [31:0] kept[$];
    res.popped_value = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (stack_shadow.size() >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stack_shadow.push_back(value);
        end
      end
      OP_POP: begin
        if (stack_shadow.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped_value = stack_shadow.pop_back();
        end
      end
      OP_REMOVE: begin
        foreach (stack_shadow[i]) begin
          if (stack_shadow[i] !== value) kept.push_back(stack_shadow[i]);
        end
        if (kept.size() == stack_shadow.size()) res.status = ST_NOTFOUND;
        stack_shadow = kept;
      end
      default: begin
      end
    endcase
    res.entry_count = 5'(stack_shadow.size());
    expected_results.push_back(res);
  endtask

  task automatic check_field(input string fname, input logic signed [31:0] expv,
                             input logic signed [31:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, fname, expv, actv);
      error_count++;
    end
  endtask

  task automatic check_result();
    stack_result_t res;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none, actual status %0d count %0d",
               $realtime, rsp_ch.status, rsp_ch.entry_count);
      error_count++;
    end else begin
      res = expected_results.pop_front();
      check_field("popped_value", res.popped_value, rsp_ch.popped_value);
      check_field("status", {30'd0, res.status}, {30'd0, rsp_ch.status});
      check_field("entry_count", {27'd0, res.entry_count}, {27'd0, rsp_ch.entry_count});
    end
  endtask

  // Command driver: a new item is loaded only when the previous transfer is done.
  always @(posedge clk) begin
    stack_cmd_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) predict_stack_op(cmd_ch.opcode, cmd_ch.data_value);
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_pending.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.opcode <= nxt.opcode;
          cmd_ch.data_value <= nxt.data_value;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_result();
      rsp_ch.ready <= (hold_left == 0) && !hold_arm &&
                      ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic queue_op(input logic [1:0] op, input logic signed [31:0] value);
    stack_cmd_t c;
    c.opcode = op;
    c.data_value = value;
    cmd_pending.push_back(c);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      default: begin
        if (recent_values.size() != 0) begin
          v = recent_values[$urandom_range(0, recent_values.size() - 1)];
        end else begin
          v = $urandom;
        end
      end
    endcase
    return v;
  endfunction

  // Traffic comes in bursts with a varying push share, so the stack swings
  // between empty and full; one key pick in four reuses a recently pushed value.
  task automatic queue_random_ops(input int n, input int min_push_pct);
    int                 push_pct;
    int                 roll;
    logic signed [31:0] v;
    push_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) push_pct = $urandom_range(min_push_pct, 80);
      roll = $urandom_range(0, 99);
      v = pick_value();
      if (roll < push_pct) begin
        queue_op(OP_PUSH, v);
        recent_values.push_back(v);
        if (recent_values.size() > 8) void'(recent_values.pop_front());
      end else if (roll < push_pct + (100 - push_pct) * 2 / 3) begin
        queue_op(OP_POP, $urandom);
      end else begin
        queue_op(OP_REMOVE, v);
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_pending.size() != 0 || expected_results.size() != 0 || cmd_ch.valid) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    @(posedge clk);
    send_idle_pct <= idle_pct;
    recv_stall_pct <= stall_pct;
    queue_random_ops(n, 20);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    queue_op(OP_POP, 32'sd0);
    queue_op(OP_REMOVE, 32'sd9);
    queue_op(OP_NOP, 32'sh1234_5678);
    queue_op(OP_PUSH, 32'sh8000_0000);
    queue_op(OP_PUSH, 32'sh7fff_ffff);
    queue_op(OP_PUSH, 32'sd0);
    queue_op(OP_PUSH, -32'sd1);
    for (int k = 0; k < DEPTH - 4; k++) begin
      queue_op(OP_PUSH, (k % 2 == 0) ? 32'sd7 : 32'(signed'($urandom)));
    end
    queue_op(OP_PUSH, 32'sh0bad_cafe);
    queue_op(OP_REMOVE, 32'sd7);
    queue_op(OP_REMOVE, 32'sh5555_aaaa);
    queue_op(OP_POP, -32'sd1);
    wait_drained();

    run_phase(0, 0, 120);
    run_phase(77, 0, 120);
    run_phase(0, 77, 120);
    run_phase(6, 6, 120);

    @(posedge clk);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_arm <= 1'b1;
    queue_random_ops(40, 60);
    @(posedge clk);
    hold_arm <= 1'b0;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
